[sv/lz_backward_decompressor_unit_defines.svh]
// ----------------------------------------------------------------------------
// Backward LZ decompressor assertion macros
// Shared checking macros for the decoder controller.
// ----------------------------------------------------------------------------
`ifndef LZ_BACKWARD_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_BACKWARD_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define LZBD_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LZBD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/lzbd_pkg.sv]
// ----------------------------------------------------------------------------
// Backward LZ decompressor package
// Types and fixed constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzbd_pkg;

   localparam int TBL_ENTRIES = 52;
   // history depth; the read address wraps on its power-of-two width
   localparam int HISTORY_DEPTH = 65536;
   localparam logic [5:0] TBL_LAST = 6'd51;
   localparam logic [5:0] SEL_NEAR = 6'd48;
   localparam logic [5:0] SEL_MID  = 6'd32;
   localparam logic [5:0] SEL_FAR  = 6'd16;
   localparam logic [4:0] ZR_END   = 5'd16;
   localparam logic [4:0] ZR_RAW   = 5'd17;
   localparam logic [4:0] ZR_MAX   = 5'd31;
   localparam logic [16:0] LEN_WRAP = 17'h10000;

   // tick sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_TWAIT,
      ST_HWAIT,
      ST_RESP
   } state_type;

   // decoder phase
   typedef enum logic [3:0] {
      PH_SEED,
      PH_TABLE,
      PH_FLAG,
      PH_ZEROS,
      PH_RUNLEN,
      PH_LEN,
      PH_OSEL,
      PH_OFFW,
      PH_OFF,
      PH_COPY,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_SEED,
      CMD_BIT,
      CMD_BYTE,
      CMD_FIN_TABLE,
      CMD_FIN_FLAG,
      CMD_TBL_RD_ZR,
      CMD_TBL_RD_TI,
      CMD_FIN_ZEROS,
      CMD_FIN_RUNLEN,
      CMD_FIN_LEN,
      CMD_FIN_OSEL,
      CMD_FIN_OFFW,
      CMD_FIN_OFF,
      CMD_HIST_RD,
      CMD_COPY_RAW,
      CMD_COPY_HIST
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pend_bits_nz;
      logic pend_bytes_nz;
      logic holder_empty;
      logic bit0;
      logic zr_end;
      logic zr_raw;
      logic entry_last;
      logic rem_le1;
   } status_type;

endpackage

[sv/lzbd_datapath.sv]
// ----------------------------------------------------------------------------
// Backward LZ decompressor datapath
// Bit holder, field gathering, base/width table, history memory and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzbd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lzbd_pkg::cmd_type   cmd,
   input  logic [7:0]          req_byte,
   output lzbd_pkg::status_type status,
   output logic [7:0]          out_byte
);

   localparam int AW = $clog2(lzbd_pkg::HISTORY_DEPTH);

   logic [8:0]  holder_ff, holder_in;
   logic [15:0] gathered_ff, gathered_in;
   logic [2:0]  pend_bits_ff, pend_bits_in;
   logic [1:0]  pend_bytes_ff, pend_bytes_in;
   logic [5:0]  entry_ff, entry_in;
   logic [15:0] rbase_ff, rbase_in;
   logic [4:0]  zero_run_ff, zero_run_in;
   logic [16:0] remaining_ff, remaining_in;
   logic [15:0] dist_ff, dist_in;
   logic [5:0]  sel_base_ff, sel_base_in;
   logic [5:0]  tab_index_ff, tab_index_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [7:0]  tick_byte_ff, tick_byte_in;
   logic [7:0]  out_byte_ff, out_byte_in;

   logic [19:0] tbl_mem [lzbd_pkg::TBL_ENTRIES];
   logic [19:0] tbl_rd_ff;
   logic        tbl_we, tbl_re;
   logic [5:0]  tbl_addr;
   logic [19:0] tbl_wdata;

   logic [7:0]  hist_mem [lzbd_pkg::HISTORY_DEPTH];
   logic [7:0]  hist_rd_ff;
   logic        hist_we, hist_re;

   logic [8:0]  refill;
   logic [15:0] base_w;
   logic [15:0] len_sum;
   logic [5:0]  sel_sum;
   logic [7:0]  copy_byte;
   logic [3:0]  rd_width;

   assign refill   = (holder_ff <= 9'd1) ? {1'b1, tick_byte_ff} : holder_ff;
   assign base_w   = (entry_ff[3:0] == 4'd0) ? 16'd1 : rbase_ff;
   assign len_sum  = tbl_rd_ff[19:4] + gathered_ff;
   assign sel_sum  = sel_base_ff + {2'b00, gathered_ff[3:0]};
   assign rd_width = tbl_rd_ff[3:0];
   assign copy_byte = (cmd.op == lzbd_pkg::CMD_COPY_RAW) ? tick_byte_ff : hist_rd_ff;

   always_comb begin
      holder_in     = holder_ff;
      gathered_in   = gathered_ff;
      pend_bits_in  = pend_bits_ff;
      pend_bytes_in = pend_bytes_ff;
      entry_in      = entry_ff;
      rbase_in      = rbase_ff;
      zero_run_in   = zero_run_ff;
      remaining_in  = remaining_ff;
      dist_in       = dist_ff;
      sel_base_in   = sel_base_ff;
      tab_index_in  = tab_index_ff;
      wp_in         = wp_ff;
      tick_byte_in  = tick_byte_ff;
      out_byte_in   = out_byte_ff;
      tbl_we        = 1'b0;
      tbl_re        = 1'b0;
      tbl_addr      = {1'b0, zero_run_ff};
      tbl_wdata     = {base_w, gathered_ff[3:0]};
      hist_we       = 1'b0;
      hist_re       = 1'b0;
      case (cmd.op)
         lzbd_pkg::CMD_CAPTURE: begin
            tick_byte_in = req_byte;
            out_byte_in  = 8'd0;
         end
         lzbd_pkg::CMD_SEED: begin
            holder_in     = {1'b0, tick_byte_ff};
            entry_in      = 6'd0;
            rbase_in      = 16'd1;
            gathered_in   = 16'd0;
            pend_bits_in  = 3'd4;
            pend_bytes_in = 2'd0;
         end
         lzbd_pkg::CMD_BIT: begin
            holder_in    = {1'b0, refill[8:1]};
            gathered_in  = {gathered_ff[14:0], refill[0]};
            pend_bits_in = pend_bits_ff - 3'd1;
         end
         lzbd_pkg::CMD_BYTE: begin
            gathered_in   = {gathered_ff[7:0], tick_byte_ff};
            pend_bytes_in = pend_bytes_ff - 2'd1;
         end
         lzbd_pkg::CMD_FIN_TABLE: begin
            tbl_we      = 1'b1;
            tbl_addr    = entry_ff;
            rbase_in    = base_w + (16'd1 << gathered_ff[3:0]);
            entry_in    = entry_ff + 6'd1;
            gathered_in = 16'd0;
            pend_bits_in = (entry_ff == lzbd_pkg::TBL_LAST) ? 3'd1 : 3'd4;
            pend_bytes_in = 2'd0;
         end
         lzbd_pkg::CMD_FIN_FLAG: begin
            if (gathered_ff[0]) begin
               remaining_in = 17'd1;
            end else begin
               zero_run_in  = 5'd0;
               gathered_in  = 16'd0;
               pend_bits_in = 3'd1;
               pend_bytes_in = 2'd0;
            end
         end
         lzbd_pkg::CMD_TBL_RD_ZR: begin
            tbl_re   = 1'b1;
            tbl_addr = {1'b0, zero_run_ff};
         end
         lzbd_pkg::CMD_TBL_RD_TI: begin
            tbl_re   = 1'b1;
            tbl_addr = tab_index_ff;
         end
         lzbd_pkg::CMD_FIN_ZEROS: begin
            if (!gathered_ff[0]) begin
               if (zero_run_ff != lzbd_pkg::ZR_MAX) begin
                  zero_run_in = zero_run_ff + 5'd1;
               end
               gathered_in   = 16'd0;
               pend_bits_in  = 3'd1;
               pend_bytes_in = 2'd0;
            end else if (zero_run_ff == lzbd_pkg::ZR_RAW) begin
               gathered_in   = 16'd0;
               pend_bits_in  = 3'd0;
               pend_bytes_in = 2'd2;
            end else if (zero_run_ff != lzbd_pkg::ZR_END) begin
               gathered_in   = 16'd0;
               pend_bits_in  = rd_width[2:0];
               pend_bytes_in = {1'b0, rd_width[3]};
            end
         end
         lzbd_pkg::CMD_FIN_RUNLEN: begin
            remaining_in = (gathered_ff == 16'd0) ? lzbd_pkg::LEN_WRAP : {1'b0, gathered_ff};
         end
         lzbd_pkg::CMD_FIN_LEN: begin
            remaining_in  = (len_sum == 16'd0) ? lzbd_pkg::LEN_WRAP : {1'b0, len_sum};
            gathered_in   = 16'd0;
            pend_bytes_in = 2'd0;
            if (len_sum == 16'd1) begin
               sel_base_in  = lzbd_pkg::SEL_NEAR;
               pend_bits_in = 3'd2;
            end else if (len_sum == 16'd2) begin
               sel_base_in  = lzbd_pkg::SEL_MID;
               pend_bits_in = 3'd4;
            end else begin
               sel_base_in  = lzbd_pkg::SEL_FAR;
               pend_bits_in = 3'd4;
            end
         end
         lzbd_pkg::CMD_FIN_OSEL: begin
            tab_index_in = (sel_sum > lzbd_pkg::TBL_LAST) ? lzbd_pkg::TBL_LAST : sel_sum;
         end
         lzbd_pkg::CMD_FIN_OFFW: begin
            gathered_in   = 16'd0;
            pend_bits_in  = rd_width[2:0];
            pend_bytes_in = {1'b0, rd_width[3]};
         end
         lzbd_pkg::CMD_FIN_OFF: begin
            dist_in = tbl_rd_ff[19:4] + gathered_ff;
         end
         lzbd_pkg::CMD_HIST_RD: begin
            hist_re = 1'b1;
         end
         lzbd_pkg::CMD_COPY_RAW, lzbd_pkg::CMD_COPY_HIST: begin
            hist_we     = 1'b1;
            out_byte_in = copy_byte;
            wp_in = (wp_ff == AW'(lzbd_pkg::HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            if (remaining_ff != 17'd0) begin
               remaining_in = remaining_ff - 17'd1;
            end
            if (remaining_ff <= 17'd1) begin
               gathered_in   = 16'd0;
               pend_bits_in  = 3'd1;
               pend_bytes_in = 2'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_ff     <= '0;
         gathered_ff   <= '0;
         pend_bits_ff  <= '0;
         pend_bytes_ff <= '0;
         entry_ff      <= '0;
         rbase_ff      <= 16'd1;
         zero_run_ff   <= '0;
         remaining_ff  <= '0;
         dist_ff       <= '0;
         sel_base_ff   <= '0;
         tab_index_ff  <= '0;
         wp_ff         <= '0;
      end else begin
         holder_ff     <= holder_in;
         gathered_ff   <= gathered_in;
         pend_bits_ff  <= pend_bits_in;
         pend_bytes_ff <= pend_bytes_in;
         entry_ff      <= entry_in;
         rbase_ff      <= rbase_in;
         zero_run_ff   <= zero_run_in;
         remaining_ff  <= remaining_in;
         dist_ff       <= dist_in;
         sel_base_ff   <= sel_base_in;
         tab_index_ff  <= tab_index_in;
         wp_ff         <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_byte_ff <= tick_byte_in;
      out_byte_ff  <= out_byte_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_addr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_addr];
      end
   end

   // history wraps on the address width
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= copy_byte;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[wp_ff - dist_ff[AW-1:0]];
      end
   end

   assign status.pend_bits_nz  = (pend_bits_ff != 3'd0);
   assign status.pend_bytes_nz = (pend_bytes_ff != 2'd0);
   assign status.holder_empty  = (holder_ff <= 9'd1);
   assign status.bit0          = gathered_ff[0];
   assign status.zr_end        = (zero_run_ff == lzbd_pkg::ZR_END);
   assign status.zr_raw        = (zero_run_ff == lzbd_pkg::ZR_RAW);
   assign status.entry_last    = (entry_ff == lzbd_pkg::TBL_LAST);
   assign status.rem_le1       = (remaining_ff <= 17'd1);
   assign out_byte             = out_byte_ff;

endmodule

[sv/lzbd_ctrl.sv]
// ----------------------------------------------------------------------------
// Backward LZ decompressor controller
// Tick sequencer and decoder phase machine driving the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lz_backward_decompressor_unit_defines.svh"

module lzbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_in_valid,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_taken,
   output logic                 rsp_emit,
   output logic                 rsp_done,
   input  lzbd_pkg::status_type status,
   output lzbd_pkg::cmd_type    cmd
);

   lzbd_pkg::state_type state_ff, state_in;
   lzbd_pkg::phase_type phase_ff, phase_in;
   logic raw_ff, raw_in;
   logic avail_ff, avail_in;
   logic taken_ff, taken_in;
   logic emit_ff, emit_in;
   logic have;

   assign have = avail_ff & ~taken_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      raw_in   = raw_ff;
      avail_in = avail_ff;
      taken_in = taken_ff;
      emit_in  = emit_ff;
      cmd.op   = lzbd_pkg::CMD_NONE;
      case (state_ff)
         lzbd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = lzbd_pkg::CMD_CAPTURE;
               avail_in = req_in_valid;
               taken_in = 1'b0;
               emit_in  = 1'b0;
               state_in = lzbd_pkg::ST_RUN;
            end
         end
         lzbd_pkg::ST_RUN: begin
            case (phase_ff)
               lzbd_pkg::PH_DONE: begin
                  state_in = lzbd_pkg::ST_RESP;
               end
               lzbd_pkg::PH_SEED: begin
                  if (have) begin
                     cmd.op   = lzbd_pkg::CMD_SEED;
                     taken_in = 1'b1;
                     phase_in = lzbd_pkg::PH_TABLE;
                  end else begin
                     state_in = lzbd_pkg::ST_RESP;
                  end
               end
               lzbd_pkg::PH_COPY: begin
                  if (!raw_ff) begin
                     cmd.op   = lzbd_pkg::CMD_HIST_RD;
                     state_in = lzbd_pkg::ST_HWAIT;
                  end else if (have) begin
                     cmd.op   = lzbd_pkg::CMD_COPY_RAW;
                     taken_in = 1'b1;
                     emit_in  = 1'b1;
                     if (status.rem_le1) begin
                        phase_in = lzbd_pkg::PH_FLAG;
                     end
                     state_in = lzbd_pkg::ST_RESP;
                  end else begin
                     state_in = lzbd_pkg::ST_RESP;
                  end
               end
               default: begin
                  if (status.pend_bits_nz) begin
                     if (status.holder_empty && !have) begin
                        state_in = lzbd_pkg::ST_RESP;
                     end else begin
                        cmd.op = lzbd_pkg::CMD_BIT;
                        if (status.holder_empty) begin
                           taken_in = 1'b1;
                        end
                     end
                  end else if (status.pend_bytes_nz) begin
                     if (have) begin
                        cmd.op   = lzbd_pkg::CMD_BYTE;
                        taken_in = 1'b1;
                     end else begin
                        state_in = lzbd_pkg::ST_RESP;
                     end
                  end else begin
                     case (phase_ff)
                        lzbd_pkg::PH_TABLE: begin
                           cmd.op = lzbd_pkg::CMD_FIN_TABLE;
                           if (status.entry_last) begin
                              phase_in = lzbd_pkg::PH_FLAG;
                           end
                        end
                        lzbd_pkg::PH_FLAG: begin
                           cmd.op = lzbd_pkg::CMD_FIN_FLAG;
                           if (status.bit0) begin
                              phase_in = lzbd_pkg::PH_COPY;
                              raw_in   = 1'b1;
                           end else begin
                              phase_in = lzbd_pkg::PH_ZEROS;
                           end
                        end
                        lzbd_pkg::PH_ZEROS, lzbd_pkg::PH_LEN: begin
                           cmd.op   = lzbd_pkg::CMD_TBL_RD_ZR;
                           state_in = lzbd_pkg::ST_TWAIT;
                        end
                        lzbd_pkg::PH_OFFW, lzbd_pkg::PH_OFF: begin
                           cmd.op   = lzbd_pkg::CMD_TBL_RD_TI;
                           state_in = lzbd_pkg::ST_TWAIT;
                        end
                        lzbd_pkg::PH_RUNLEN: begin
                           cmd.op   = lzbd_pkg::CMD_FIN_RUNLEN;
                           phase_in = lzbd_pkg::PH_COPY;
                           raw_in   = 1'b1;
                        end
                        lzbd_pkg::PH_OSEL: begin
                           cmd.op   = lzbd_pkg::CMD_FIN_OSEL;
                           phase_in = lzbd_pkg::PH_OFFW;
                        end
                        default: begin
                           phase_in = lzbd_pkg::PH_DONE;
                        end
                     endcase
                  end
               end
            endcase
         end
         lzbd_pkg::ST_TWAIT: begin
            state_in = lzbd_pkg::ST_RUN;
            case (phase_ff)
               lzbd_pkg::PH_ZEROS: begin
                  cmd.op = lzbd_pkg::CMD_FIN_ZEROS;
                  if (status.bit0) begin
                     if (status.zr_end) begin
                        phase_in = lzbd_pkg::PH_DONE;
                     end else if (status.zr_raw) begin
                        phase_in = lzbd_pkg::PH_RUNLEN;
                     end else begin
                        phase_in = lzbd_pkg::PH_LEN;
                     end
                  end
               end
               lzbd_pkg::PH_LEN: begin
                  cmd.op   = lzbd_pkg::CMD_FIN_LEN;
                  phase_in = lzbd_pkg::PH_OSEL;
               end
               lzbd_pkg::PH_OFFW: begin
                  cmd.op   = lzbd_pkg::CMD_FIN_OFFW;
                  phase_in = lzbd_pkg::PH_OFF;
               end
               lzbd_pkg::PH_OFF: begin
                  cmd.op   = lzbd_pkg::CMD_FIN_OFF;
                  phase_in = lzbd_pkg::PH_COPY;
                  raw_in   = 1'b0;
               end
               default: begin
                  phase_in = lzbd_pkg::PH_DONE;
               end
            endcase
         end
         lzbd_pkg::ST_HWAIT: begin
            cmd.op  = lzbd_pkg::CMD_COPY_HIST;
            emit_in = 1'b1;
            if (status.rem_le1) begin
               phase_in = lzbd_pkg::PH_FLAG;
            end
            state_in = lzbd_pkg::ST_RESP;
         end
         lzbd_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = lzbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzbd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzbd_pkg::ST_IDLE;
         phase_ff <= lzbd_pkg::PH_SEED;
         raw_ff   <= 1'b0;
         avail_ff <= 1'b0;
         taken_ff <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         raw_ff   <= raw_in;
         avail_ff <= avail_in;
         taken_ff <= taken_in;
         emit_ff  <= emit_in;
      end
   end

   assign req_tready = (state_ff == lzbd_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == lzbd_pkg::ST_RESP);
   assign rsp_taken  = taken_ff;
   assign rsp_emit   = emit_ff;
   assign rsp_done   = (phase_ff == lzbd_pkg::PH_DONE);

   `LZBD_ASSERT_NOW(a_taken_needs_offer, taken_ff, avail_ff, "byte taken without an offer")
   `LZBD_ASSERT_NEXT(a_hist_to_resp, state_ff == lzbd_pkg::ST_HWAIT, state_ff == lzbd_pkg::ST_RESP && emit_ff, "history copy did not emit")
   `LZBD_ASSERT_NEXT(a_twait_returns, state_ff == lzbd_pkg::ST_TWAIT, state_ff == lzbd_pkg::ST_RUN, "table wait did not return to run")
   `LZBD_ASSERT_NEXT(a_done_ends_tick, state_ff == lzbd_pkg::ST_RUN && phase_ff == lzbd_pkg::PH_DONE, state_ff == lzbd_pkg::ST_RESP && !emit_ff, "end phase kept decoding")

endmodule

[sv/lz_backward_decompressor_unit.sv]
// Sequencing: a tick from req word to rsp word spends a step on each holder bit, each
// whole byte and each field close, plus one table read per match field and per
// zero-run bit and one history read per copied byte; the bit-serial holder sets most of it.
// Throughput: one req word in flight; req_tready returns the cycle after the rsp word leaves.
// Reset: synchronous, clears the bit holder, counters and decoder phase; tables and
// history hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
// Backward LZ decompressor top level
// Stream wrapper joining the decoder controller and its datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lz_backward_decompressor_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // in_valid
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [2:0] rsp_tuser    // byte_taken, out_valid, done_res
);

   lzbd_pkg::cmd_type    cmd;
   lzbd_pkg::status_type status;
   logic taken, emit, done;

   lzbd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_in_valid (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_taken    (taken),
      .rsp_emit     (emit),
      .rsp_done     (done),
      .status       (status),
      .cmd          (cmd)
   );

   lzbd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_byte (req_tdata),
      .status   (status),
      .out_byte (rsp_tdata)
   );

   assign rsp_tuser = {done, emit, taken};

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Backward LZ decompressor testbench
// Builds one well-formed compressed stream (table, literals, matches, raw runs,
// end code), feeds it a word per tick and checks every response word against fixed
// rows or a bit-accurate decoder model kept in step with the requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_LEN = 200;

   typedef struct packed {
      logic [2:0] user;   // byte_taken, out_valid, done_res
      logic [7:0] data;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic       known;
      logic [2:0] user;
   } tick_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // in_byte
   logic       req_tuser = 1'b0;    // in_valid
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic [2:0] rsp_tuser;           // byte_taken, out_valid, done_res

   lz_backward_decompressor_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // decoder model state
   logic [15:0] holder;
   logic [15:0] base_tbl [lzbd_pkg::TBL_ENTRIES];
   logic [3:0]  wid_tbl [lzbd_pkg::TBL_ENTRIES];
   logic [7:0]  hist [65536];
   logic [15:0] wptr;
   lzbd_pkg::phase_type ph;
   logic [5:0]  entry_cnt;
   logic [15:0] run_base;
   logic [4:0]  zrun;
   logic [15:0] gathered;
   logic [16:0] remaining;
   logic [15:0] distance;
   logic [3:0]  pend_bits;
   logic [1:0]  pend_bytes;
   logic        raw_copy;
   logic [5:0]  sel_base;
   logic [5:0]  tab_idx;

   // stream builder state
   logic [7:0]  stream_bytes [$];
   int          fill_pos;
   int          fill_bit;
   int          bits_left;
   int          enc_width [lzbd_pkg::TBL_ENTRIES];
   logic [15:0] enc_base [lzbd_pkg::TBL_ENTRIES];
   int          written;

   rsp_word_type expected_bytes [$];
   int          errors = 0;
   int          mismatches = 0;

   task automatic start_read(input logic [3:0] n);
      gathered = 16'd0;
      if (n >= 4'd8) begin
         pend_bits = n - 4'd8;
         pend_bytes = 2'd1;
      end else begin
         pend_bits = n;
         pend_bytes = 2'd0;
      end
   endtask

   task automatic finish_read();
      logic [15:0] v;
      logic [15:0] len;
      logic [6:0]  ti;
      v = gathered;
      case (ph)
         lzbd_pkg::PH_TABLE: begin
            if (entry_cnt[3:0] == 4'd0) run_base = 16'd1;
            base_tbl[entry_cnt] = run_base;
            wid_tbl[entry_cnt] = v[3:0];
            run_base = run_base + (16'd1 << v[3:0]);
            entry_cnt = entry_cnt + 6'd1;
            if (entry_cnt >= lzbd_pkg::TBL_ENTRIES) begin
               ph = lzbd_pkg::PH_FLAG;
               start_read(4'd1);
            end else begin
               start_read(4'd4);
            end
         end
         lzbd_pkg::PH_FLAG: begin
            if (v[0]) begin
               raw_copy = 1'b1;
               remaining = 17'd1;
               ph = lzbd_pkg::PH_COPY;
            end else begin
               zrun = 5'd0;
               ph = lzbd_pkg::PH_ZEROS;
               start_read(4'd1);
            end
         end
         lzbd_pkg::PH_ZEROS: begin
            if (!v[0]) begin
               if (zrun < lzbd_pkg::ZR_MAX) zrun = zrun + 5'd1;
               start_read(4'd1);
            end else if (zrun == lzbd_pkg::ZR_END) begin
               ph = lzbd_pkg::PH_DONE;
            end else if (zrun == lzbd_pkg::ZR_RAW) begin
               ph = lzbd_pkg::PH_RUNLEN;
               gathered = 16'd0;
               pend_bits = 4'd0;
               pend_bytes = 2'd2;
            end else begin
               ph = lzbd_pkg::PH_LEN;
               start_read(wid_tbl[zrun]);
            end
         end
         lzbd_pkg::PH_RUNLEN: begin
            remaining = (v != 16'd0) ? {1'b0, v} : lzbd_pkg::LEN_WRAP;
            raw_copy = 1'b1;
            ph = lzbd_pkg::PH_COPY;
         end
         lzbd_pkg::PH_LEN: begin
            len = base_tbl[zrun] + v;
            remaining = (len != 16'd0) ? {1'b0, len} : lzbd_pkg::LEN_WRAP;
            ph = lzbd_pkg::PH_OSEL;
            if (len == 16'd1) begin
               sel_base = lzbd_pkg::SEL_NEAR;
               start_read(4'd2);
            end else if (len == 16'd2) begin
               sel_base = lzbd_pkg::SEL_MID;
               start_read(4'd4);
            end else begin
               sel_base = lzbd_pkg::SEL_FAR;
               start_read(4'd4);
            end
         end
         lzbd_pkg::PH_OSEL: begin
            ti = {1'b0, sel_base} + {3'd0, v[3:0]};
            tab_idx = (ti > {1'b0, lzbd_pkg::TBL_LAST}) ? lzbd_pkg::TBL_LAST : ti[5:0];
            ph = lzbd_pkg::PH_OFF;
            start_read(wid_tbl[tab_idx]);
         end
         lzbd_pkg::PH_OFF: begin
            distance = base_tbl[tab_idx] + v;
            raw_copy = 1'b0;
            ph = lzbd_pkg::PH_COPY;
         end
         default: ph = lzbd_pkg::PH_DONE;
      endcase
   endtask

   // one tick of the decoder: at most one byte consumed, at most one emitted
   task automatic decode_tick(input logic avail, input logic [7:0] b,
                              output logic taken, output logic emitted,
                              output logic [7:0] ob, output logic done);
      logic       stop;
      logic [7:0] c;
      stop = 1'b0;
      taken = 1'b0;
      emitted = 1'b0;
      ob = 8'h00;
      while (!stop) begin
         if (ph == lzbd_pkg::PH_DONE) begin
            stop = 1'b1;
         end else if (ph == lzbd_pkg::PH_SEED) begin
            if (!avail || taken) begin
               stop = 1'b1;
            end else begin
               taken = 1'b1;
               holder = {8'h00, b};
               ph = lzbd_pkg::PH_TABLE;
               entry_cnt = 6'd0;
               run_base = 16'd1;
               start_read(4'd4);
            end
         end else if (ph == lzbd_pkg::PH_COPY) begin
            if (raw_copy && (!avail || taken)) begin
               stop = 1'b1;
            end else begin
               if (raw_copy) begin
                  taken = 1'b1;
                  c = b;
               end else begin
                  c = hist[wptr - distance];
               end
               hist[wptr] = c;
               wptr = wptr + 16'd1;
               if (remaining > 17'd0) remaining = remaining - 17'd1;
               if (remaining == 17'd0) begin
                  ph = lzbd_pkg::PH_FLAG;
                  start_read(4'd1);
               end
               emitted = 1'b1;
               ob = c;
               stop = 1'b1;
            end
         end else if (pend_bits > 4'd0) begin
            if (holder <= 16'd1 && (!avail || taken)) begin
               stop = 1'b1;
            end else begin
               if (holder <= 16'd1) begin
                  taken = 1'b1;
                  holder = 16'h100 | {8'h00, b};
               end
               gathered = {gathered[14:0], holder[0]};
               holder = holder >> 1;
               pend_bits = pend_bits - 4'd1;
            end
         end else if (pend_bytes > 2'd0) begin
            if (!avail || taken) begin
               stop = 1'b1;
            end else begin
               taken = 1'b1;
               gathered = {gathered[7:0], b};
               pend_bytes = pend_bytes - 2'd1;
            end
         end else begin
            finish_read();
         end
      end
      done = (ph == lzbd_pkg::PH_DONE);
   endtask

   // holder bits go into the low end of each refill word first
   task automatic put_bit(input int b);
      if (bits_left == 0) begin
         fill_pos = stream_bytes.size();
         stream_bytes.push_back(8'h00);
         fill_bit = 0;
         bits_left = 8;
      end
      stream_bytes[fill_pos][fill_bit] = b[0];
      fill_bit++;
      bits_left--;
   endtask

   task automatic put_field(input int n, input int v);
      if (n >= 8) begin
         for (int i = n - 1; i >= 8; i--) put_bit((v >> i) & 1);
         stream_bytes.push_back(v[7:0]);
      end else begin
         for (int i = n - 1; i >= 0; i--) put_bit((v >> i) & 1);
      end
   endtask

   task automatic put_code(input int z);
      put_bit(0);
      repeat (z) put_bit(0);
      put_bit(1);
   endtask

   task automatic emit_raw_run(input int len);
      put_code(lzbd_pkg::ZR_RAW);
      stream_bytes.push_back(len[15:8]);
      stream_bytes.push_back(len[7:0]);
      repeat (len) stream_bytes.push_back($urandom_range(255, 0));
      written += len;
   endtask

   task automatic emit_literal();
      put_bit(1);
      stream_bytes.push_back($urandom_range(255, 0));
      written++;
   endtask

   // keep every match inside written history and its length modest
   task automatic emit_match(input int z, input int vreq);
      int idx, w, vmax, v, len, sel, nb, ti, s, dmax;
      int picks [$];
      idx = (z > lzbd_pkg::ZR_MAX) ? lzbd_pkg::ZR_MAX : z;
      w = enc_width[idx];
      vmax = (1 << w) - 1;
      if (vmax > MAX_LEN - enc_base[idx]) vmax = MAX_LEN - enc_base[idx];
      v = (vreq >= 0) ? vreq : $urandom_range(vmax, 0);
      len = enc_base[idx] + v;
      put_code(z);
      put_field(w, v);
      if (len == 1) begin
         sel = lzbd_pkg::SEL_NEAR;
         nb = 2;
      end else if (len == 2) begin
         sel = lzbd_pkg::SEL_MID;
         nb = 4;
      end else begin
         sel = lzbd_pkg::SEL_FAR;
         nb = 4;
      end
      for (int k = 0; k < (1 << nb); k++) begin
         ti = (sel + k > lzbd_pkg::TBL_LAST) ? lzbd_pkg::TBL_LAST : sel + k;
         if (enc_base[ti] >= 1 && enc_base[ti] <= written) picks.push_back(k);
      end
      s = picks[$urandom_range(picks.size() - 1, 0)];
      ti = (sel + s > lzbd_pkg::TBL_LAST) ? lzbd_pkg::TBL_LAST : sel + s;
      put_field(nb, s);
      dmax = (1 << enc_width[ti]) - 1;
      if (dmax > written - enc_base[ti]) dmax = written - enc_base[ti];
      put_field(enc_width[ti], $urandom_range(dmax, 0));
      written += len;
   endtask

   task automatic build_stream();
      logic [15:0] rb;
      int          z, r;
      stream_bytes.delete();
      // zero seed: the first bit already forces a refill
      stream_bytes.push_back(8'h00);
      bits_left = 0;
      written = 0;
      rb = 16'd1;
      for (int i = 0; i < lzbd_pkg::TBL_ENTRIES; i++) begin
         if (i < 16) enc_width[i] = $urandom_range(9, 0);
         else if (i < 32) enc_width[i] = $urandom_range(3, 0);
         else enc_width[i] = $urandom_range(10, 0);
      end
      enc_width[0] = 1;
      enc_width[5] = 9;
      enc_width[33] = 8;
      enc_width[47] = 15;
      for (int i = 0; i < lzbd_pkg::TBL_ENTRIES; i++) begin
         if (i % 16 == 0) rb = 16'd1;
         enc_base[i] = rb;
         rb = rb + (16'd1 << enc_width[i]);
         put_field(4, enc_width[i]);
      end
      // directed opening: long raw run, literal, short and long matches,
      // then a zero run that saturates and a one-byte raw run
      emit_raw_run(261);
      emit_literal();
      emit_match(0, 0);
      emit_match(0, 1);
      emit_match(1, -1);
      emit_match(35, -1);
      emit_raw_run(1);
      while (written < 1150) begin
         r = $urandom_range(99, 0);
         if (r < 30) begin
            emit_literal();
         end else if (r < 40) begin
            emit_raw_run($urandom_range(30, 1));
         end else begin
            do z = $urandom_range(40, 0);
            while (z == lzbd_pkg::ZR_END || z == lzbd_pkg::ZR_RAW
                   || enc_base[(z > lzbd_pkg::ZR_MAX) ? lzbd_pkg::ZR_MAX : z] < 1
                   || enc_base[(z > lzbd_pkg::ZR_MAX) ? lzbd_pkg::ZR_MAX : z] > MAX_LEN);
            emit_match(z, -1);
         end
      end
      put_code(lzbd_pkg::ZR_END);
   endtask

   bit idle_on = 1'b1;

   task automatic send_tick(input logic v, input logic [7:0] b, input logic known,
                            input logic [2:0] typed, output logic taken,
                            output logic done);
      logic       o;
      logic [7:0] ob;
      if (idle_on && $urandom_range(99, 0) < 30) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = v;
      req_tdata = b;
      do @(posedge clock); while (!req_tready);
      decode_tick(v, b, taken, o, ob, done);
      if (known) expected_bytes.push_back('{typed, 8'h00});
      else expected_bytes.push_back('{{done, o, taken}, ob});
      @(negedge clock);
   endtask

   task automatic note_mismatch(input rsp_word_type want);
      errors++;
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: expected user %b data %h, got user %b data %h",
                  want.user, want.data, rsp_tuser, rsp_tdata);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("unexpected rsp word: user %b data %h", rsp_tuser, rsp_tdata);
         end else begin
            want = expected_bytes.pop_front();
            if (want.user !== rsp_tuser || want.data !== rsp_tdata) note_mismatch(want);
         end
      end
   end

   // receiver: random back-pressure, a clean stretch and one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= 6000 && cyc < 6400) rsp_tready = 1'b0;
         else if (cyc >= 2000 && cyc < 4000) rsp_tready = 1'b1;
         else rsp_tready = ($urandom_range(99, 0) >= 30);
      end
   end

   initial begin
      #5_000_000;
      $display("lz_backward_decompressor_unit: mismatch");
      $finish;
   end

   initial begin
      tick_row_type dir_rows [10];
      int           idx, n;
      logic         taken, done, v;
      logic [7:0]   b;

      dir_rows = '{
         '{1'b0, 1'b1, 3'b000},   // before the seed nothing moves
         '{1'b0, 1'b1, 3'b000},
         '{1'b0, 1'b1, 3'b000},
         '{1'b1, 1'b1, 3'b001},   // seed taken, table needs the next word
         '{1'b1, 1'b0, 3'b000},
         '{1'b0, 1'b0, 3'b000},
         '{1'b1, 1'b0, 3'b000},
         '{1'b1, 1'b0, 3'b000},
         '{1'b0, 1'b0, 3'b000},
         '{1'b1, 1'b0, 3'b000}
      };

      holder = 16'd0;
      wptr = 16'd0;
      ph = lzbd_pkg::PH_SEED;
      entry_cnt = 6'd0;
      run_base = 16'd1;
      zrun = 5'd0;
      gathered = 16'd0;
      remaining = 17'd0;
      distance = 16'd0;
      pend_bits = 4'd0;
      pend_bytes = 2'd0;
      raw_copy = 1'b0;
      sel_base = 6'd0;
      tab_idx = 6'd0;
      build_stream();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idx = 0;
      done = 1'b0;
      foreach (dir_rows[i]) begin
         v = dir_rows[i].valid;
         b = v ? stream_bytes[idx] : 8'($urandom_range(255, 0));
         send_tick(v, b, dir_rows[i].known, dir_rows[i].user, taken, done);
         if (taken) idx++;
      end

      n = 0;
      while (!done && n < 6000) begin
         n++;
         idle_on = !(n >= 200 && n < 450);
         if (n == 600) begin
            // drain everything before going on
            req_tvalid = 1'b0;
            while (expected_bytes.size() != 0) @(negedge clock);
         end
         v = (idx < stream_bytes.size()) && ($urandom_range(9, 0) != 0);
         b = v ? stream_bytes[idx] : 8'($urandom_range(255, 0));
         send_tick(v, b, 1'b0, 3'b000, taken, done);
         if (taken) idx++;
      end
      // past the end code every word is ignored
      repeat (20) send_tick(1'b1, 8'($urandom_range(255, 0)), 1'b0, 3'b000, taken, done);
      req_tvalid = 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("lz_backward_decompressor_unit: match");
      end else begin
         $display("lz_backward_decompressor_unit: mismatch");
      end
      $finish;
   end

endmodule
